### rtl/core/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared types and constants for the XOR checksum frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd170;
    localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'd85;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST    = 8'd64;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER  = 2'd0,
        CFG_END_MARKER    = 2'd1,
        CFG_MAX_LENGTH    = 2'd2,
        CFG_TIMEOUT_TICKS = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_LENGTH   = 2'd0,
        ERR_CHECKSUM = 2'd1,
        ERR_END      = 2'd2,
        ERR_TIMEOUT  = 2'd3
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [BYTE_W-1:0] max_length;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [1:0]        err;
    } result_t;

endpackage

### rtl/core/xor_checksum_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_unit
// Deframer for start/end delimited packets with an XOR checksum.
// ----------------------------------------------------------------------------
// Each input item is one received byte or one poll tick; one item is taken
// per clock while s_ready is high. Each payload byte, accept or reject result
// is registered before it appears on the m_ port. Results go to an output
// register backed by one skid entry, so s_ready drops only while two results
// wait downstream. Configuration writes take effect on the next cycle and are
// meant to be made while no frame is in flight.
module xor_checksum_frame_parser_unit
    import xcfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_result_kind,
    output logic [BYTE_W-1:0]     m_data_byte,
    output logic [BYTE_W-1:0]     m_command,
    output logic [BYTE_W-1:0]     m_length,
    output logic [1:0]            m_error_code,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t step_res;
    result_t out_res;
    logic    step_res_valid;
    logic    can_push;
    logic    s_accept;

    assign s_ready  = can_push;
    assign s_accept = s_valid && can_push;

    xcfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xcfp_deframer u_deframer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s_accept),
        .operation (s_operation),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg),
        .res_valid (step_res_valid),
        .res       (step_res)
    );

    xcfp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .can_push (can_push),
        .push     (step_res_valid),
        .push_res (step_res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_result_kind = out_res.kind;
    assign m_data_byte   = out_res.data;
    assign m_command     = out_res.command;
    assign m_length      = out_res.length;
    assign m_error_code  = out_res.err;

endmodule

### rtl/core/xcfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// xcfp_cfg_regs
// Configuration register file: markers, length limit and idle timeout.
// ----------------------------------------------------------------------------
module xcfp_cfg_regs
    import xcfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_MARKER:  cfg_next.start_marker  = cfg_data[BYTE_W-1:0];
                CFG_END_MARKER:    cfg_next.end_marker    = cfg_data[BYTE_W-1:0];
                CFG_MAX_LENGTH:    cfg_next.max_length    = cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker  <= START_MARKER_RST;
            cfg_reg.end_marker    <= END_MARKER_RST;
            cfg_reg.max_length    <= MAX_LENGTH_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/xcfp_deframer.sv
// ----------------------------------------------------------------------------
// xcfp_deframer
// Frame state machine: one byte or tick per cycle while step is high, at most one result.
// ----------------------------------------------------------------------------
module xcfp_deframer
    import xcfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              operation,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              res_valid,
    output result_t           res
);

    phase_t            phase_reg,   phase_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] length_reg,  length_next;
    logic [BYTE_W-1:0] seen_reg,    seen_next;
    logic [BYTE_W-1:0] xor_reg,     xor_next;
    logic [BYTE_W-1:0] csum_reg,    csum_next;
    logic [TICK_W-1:0] idle_reg,    idle_next;
    logic [TICK_W-1:0] idle_inc;
    logic [BYTE_W-1:0] seen_inc;
    logic              is_tick;

    assign is_tick  = (op_t'(operation) == OP_TICK);
    assign idle_inc = idle_reg + 1'b1;
    assign seen_inc = seen_reg + 1'b1;

    always_comb begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        xor_next     = xor_reg;
        csum_next    = csum_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        res.kind     = KIND_DATA;
        res.data     = '0;
        res.err      = ERR_LENGTH;

        if (step) begin
            if (phase_reg == PH_HUNT) begin
                if (!is_tick && rx_byte == cfg.start_marker) begin
                    phase_next   = PH_CMD;
                    command_next = '0;
                    length_next  = '0;
                    seen_next    = '0;
                    xor_next     = '0;
                    csum_next    = '0;
                    idle_next    = '0;
                end
            end else if (is_tick) begin
                idle_next = idle_inc;
                if (idle_inc == cfg.timeout_ticks) begin
                    res_valid  = 1'b1;
                    res.kind   = KIND_REJECT;
                    res.err    = ERR_TIMEOUT;
                    phase_next = PH_HUNT;
                end
            end else begin
                idle_next = '0;
                unique case (phase_reg)
                    PH_CMD: begin
                        command_next = rx_byte;
                        xor_next     = rx_byte;
                        phase_next   = PH_LEN;
                    end
                    PH_LEN: begin
                        length_next = rx_byte;
                        xor_next    = xor_reg ^ rx_byte;
                        seen_next   = '0;
                        if (rx_byte > cfg.max_length) begin
                            res_valid  = 1'b1;
                            res.kind   = KIND_REJECT;
                            res.err    = ERR_LENGTH;
                            phase_next = PH_HUNT;
                        end else if (rx_byte == '0) begin
                            phase_next = PH_CSUM;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        xor_next  = xor_reg ^ rx_byte;
                        seen_next = seen_inc;
                        if (seen_inc == length_reg) begin
                            phase_next = PH_CSUM;
                        end
                        res_valid = 1'b1;
                        res.kind  = KIND_DATA;
                        res.data  = rx_byte;
                    end
                    PH_CSUM: begin
                        csum_next  = rx_byte;
                        phase_next = PH_END;
                    end
                    PH_END: begin
                        res_valid  = 1'b1;
                        phase_next = PH_HUNT;
                        priority if (csum_reg != xor_reg) begin
                            res.kind = KIND_REJECT;
                            res.err  = ERR_CHECKSUM;
                        end else if (rx_byte != cfg.end_marker) begin
                            res.kind = KIND_REJECT;
                            res.err  = ERR_END;
                        end else begin
                            res.kind = KIND_ACCEPT;
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end

        res.command = command_next;
        res.length  = length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            command_reg <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
            xor_reg     <= '0;
            csum_reg    <= '0;
            idle_reg    <= '0;
        end else begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            xor_reg     <= xor_next;
            csum_reg    <= csum_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

### rtl/core/xcfp_out_buf.sv
// ----------------------------------------------------------------------------
// xcfp_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module xcfp_out_buf
    import xcfp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    output logic    can_push,
    input  logic    push,
    input  result_t push_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg,        out_next;
    result_t skid_reg,       skid_next;
    logic    pop;

    assign can_push = !skid_valid_reg;
    assign pop      = out_valid_reg && m_ready;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = push_res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
